@@ design/nlp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the next lexicographic permutation block.
// Depends on nothing; every other file imports it.
package nlp_pkg;

   localparam int MaxLenDefault      = 16;
   localparam int ElementBitsDefault = 16;

   // Slot index field in the queue: wide enough for the largest supported length.
   localparam int SlotBits   = 7;
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = $clog2(QueueDepth);
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [15:0] element_value;
      logic        is_last;
   } nlp_req_type;

   typedef struct packed {
      logic [15:0] out_value;
      logic [3:0]  out_position;
      logic        out_last;
      logic        has_next;
   } nlp_rsp_type;

   // One classified beat handed from the front to the back.
   typedef struct packed {
      logic [15:0]         value;
      logic [SlotBits-1:0] slot;
      logic                keep;
      logic                last;
   } nlp_cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } nlp_qstat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SWAP_WR,
      ST_REV_RD,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_EMIT_RD,
      ST_EMIT
   } nlp_state_type;

endpackage

@@ design/nlp_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, assigns store slots, flags overflow beats.
// Depends on nlp_pkg.
module nlp_front #(
   parameter int MAX_LEN = nlp_pkg::MaxLenDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  nlp_pkg::nlp_req_type req,
   output logic                 push,
   output nlp_pkg::nlp_cmd_type cmd
);
   import nlp_pkg::*;

   localparam int CntBits = $clog2(MAX_LEN + 1);

   logic [CntBits-1:0] count_ff, count_in;
   logic               keep;

   assign keep = count_ff < CntBits'(MAX_LEN);
   assign push = accept;

   always_comb begin
      cmd.value = req.element_value;
      cmd.slot  = SlotBits'(count_ff);
      cmd.keep  = keep;
      cmd.last  = req.is_last;
   end

   // Advance the fill count on stored beats; restart after the last beat.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req.is_last) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ design/nlp_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO between front and back so that each side stalls on its own.
// Depends on nlp_pkg.
module nlp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nlp_pkg::nlp_cmd_type   push_cmd,
   input  logic                   pop,
   output nlp_pkg::nlp_cmd_type   head_cmd,
   output nlp_pkg::nlp_qstat_type stat
);
   import nlp_pkg::*;

   nlp_cmd_type         entries_ff [QueueDepth];
   logic [QPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntBits-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign stat.full      = cnt_ff == QCntBits'(QueueDepth);
   assign stat.not_empty = cnt_ff != '0;
   assign do_push        = push && !stat.full;
   assign do_pop         = pop && stat.not_empty;
   assign head_cmd       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QueueDepth - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QueueDepth - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/nlp_back.sv @@
`timescale 1ns / 1ps
// Back end: sequence store, permutation step sequencer and result emitter.
// Depends on nlp_pkg.
module nlp_back #(
   parameter int MAX_LEN      = nlp_pkg::MaxLenDefault,
   parameter int ELEMENT_BITS = nlp_pkg::ElementBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nlp_pkg::nlp_qstat_type qstat,
   input  nlp_pkg::nlp_cmd_type   head_cmd,
   output logic                   pop,
   output logic                   rsp_strobe,
   output nlp_pkg::nlp_rsp_type   rsp_data
);
   import nlp_pkg::*;

   localparam int AddrBits = $clog2(MAX_LEN);
   localparam int CntBits  = $clog2(MAX_LEN + 1);

   logic [ELEMENT_BITS-1:0] store_ff [MAX_LEN];
   logic [ELEMENT_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [AddrBits-1:0]     rd_addr_a, rd_addr_b, wr_addr;
   logic [ELEMENT_BITS-1:0] wr_data;
   logic                    wr_en;

   nlp_state_type           state_ff, state_in;
   logic [CntBits-1:0]      n_ff, n_in, n_head;
   logic [AddrBits-1:0]     j_ff, j_in;
   logic [AddrBits-1:0]     k_ff, k_in;
   logic [AddrBits-1:0]     lo_ff, lo_in;
   logic [AddrBits-1:0]     hi_ff, hi_in;
   logic [AddrBits-1:0]     idx_ff, idx_in;
   logic [ELEMENT_BITS-1:0] piv_val_ff, piv_val_in;
   logic                    more_ff, more_in;
   logic                    strobe_ff, strobe_in;
   nlp_rsp_type             rsp_ff, rsp_in;
   logic [AddrBits-1:0]     last_addr;

   assign n_head    = CntBits'(head_cmd.slot) + CntBits'(head_cmd.keep);
   assign last_addr = AddrBits'(n_ff - 1'b1);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      piv_val_in = piv_val_ff;
      more_in    = more_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      pop        = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = AddrBits'(head_cmd.slot);
      wr_data    = ELEMENT_BITS'(head_cmd.value);
      rd_addr_a  = j_ff;
      rd_addr_b  = AddrBits'(j_ff + 1'b1);
      case (state_ff)
         ST_IDLE: begin
            if (qstat.not_empty) begin
               pop   = 1'b1;
               wr_en = head_cmd.keep;
               if (head_cmd.last) begin
                  n_in   = n_head;
                  idx_in = '0;
                  if (n_head < CntBits'(2)) begin
                     more_in  = 1'b0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     j_in     = AddrBits'(n_head - CntBits'(2));
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (rd_a_ff >= rd_b_ff) begin
               if (j_ff == '0) begin
                  more_in  = 1'b0;
                  state_in = ST_EMIT_RD;
               end else begin
                  j_in     = j_ff - 1'b1;
                  state_in = ST_SCAN_RD;
               end
            end else begin
               piv_val_in = rd_a_ff;
               k_in       = last_addr;
               state_in   = ST_FIND_RD;
            end
         end
         ST_FIND_RD: begin
            rd_addr_a = k_ff;
            state_in  = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (piv_val_ff >= rd_a_ff) begin
               k_in     = k_ff - 1'b1;
               state_in = ST_FIND_RD;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = j_ff;
               wr_data  = rd_a_ff;
               state_in = ST_SWAP_WR;
            end
         end
         ST_SWAP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = piv_val_ff;
            more_in  = 1'b1;
            lo_in    = AddrBits'(j_ff + 1'b1);
            hi_in    = last_addr;
            state_in = ST_REV_RD;
         end
         ST_REV_RD: begin
            rd_addr_a = lo_ff;
            rd_addr_b = hi_ff;
            if (lo_ff < hi_ff) begin
               state_in = ST_REV_WR_LO;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_REV_WR_LO: begin
            // Hold the old low entry on read port a for the high write.
            rd_addr_a = lo_ff;
            wr_en     = 1'b1;
            wr_addr   = lo_ff;
            wr_data   = rd_b_ff;
            state_in  = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = rd_a_ff;
            lo_in    = lo_ff + 1'b1;
            hi_in    = hi_ff - 1'b1;
            state_in = ST_REV_RD;
         end
         ST_EMIT_RD: begin
            rd_addr_a = idx_ff;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rd_addr_a           = AddrBits'(idx_ff + 1'b1);
            strobe_in           = 1'b1;
            rsp_in.out_value    = 16'(rd_a_ff);
            rsp_in.out_position = 4'(idx_ff);
            rsp_in.out_last     = idx_ff == last_addr;
            rsp_in.has_next     = more_ff;
            if (idx_ff == last_addr) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      piv_val_ff <= piv_val_in;
      more_ff    <= more_in;
      rsp_ff     <= rsp_in;
   end

   // Sequence store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ design/next_lexicographic_permutation.sv @@
`timescale 1ns / 1ps
// Top level of the next lexicographic permutation block.
// Depends on nlp_pkg, nlp_front, nlp_queue and nlp_back.
//
// Feed a sequence one element per beat (start high while busy is low) and
// mark its final element with is_last. That beat replaces the stored sequence
// with its next permutation in ascending lexicographic order (duplicates
// allowed) and then streams every element out, one beat per cycle on
// rsp_strobe, with its position, a last marker and has_next, which is 0 when
// the sequence was already the final permutation and is emitted unchanged.
// Elements beyond MAX_LEN are dropped; the step then runs on the stored ones.
// The receiver cannot stall: each result is flagged by rsp_strobe for one cycle
// only, so sample it whenever rsp_strobe is high. Element beats load at one
// per cycle through a two-entry queue; busy rises only when that queue is
// full while the back end works on a step. Once the last beat leaves the queue,
// a step scans for the pivot, tests candidates for the swap partner from the
// end, swaps the two, reverses the suffix one exchanged pair at a time and
// then emits; the sequence store, with one write port and two registered
// read ports, reads two entries and writes one per cycle.
module next_lexicographic_permutation #(
   parameter int MAX_LEN      = nlp_pkg::MaxLenDefault,
   parameter int ELEMENT_BITS = nlp_pkg::ElementBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  nlp_pkg::nlp_req_type req_data,
   output logic                 rsp_strobe,
   output nlp_pkg::nlp_rsp_type rsp_data
);
   import nlp_pkg::*;

   logic          accept;
   logic          push;
   logic          pop;
   nlp_cmd_type   push_cmd;
   nlp_cmd_type   head_cmd;
   nlp_qstat_type qstat;

   // Take a beat whenever the queue has room.
   assign busy   = qstat.full;
   assign accept = start && !busy;

   // Assign slots and flag overflow elements.
   nlp_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push),
      .cmd    (push_cmd)
   );

   // Decouple loading from the permutation step.
   nlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (qstat)
   );

   // Store, permute and emit.
   nlp_back #(
      .MAX_LEN      (MAX_LEN),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
